FILE: src/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MODE_W = 3;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 2;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [MODE_W-1:0] t_mode_code;
    typedef logic [STAT_W-1:0] t_stat_code;

    localparam t_mode_code MODE_PUSH_TAIL = MODE_W'(0);
    localparam t_mode_code MODE_PUSH_HEAD = MODE_W'(1);
    localparam t_mode_code MODE_POP_HEAD  = MODE_W'(2);
    localparam t_mode_code MODE_SWAP      = MODE_W'(3);
    localparam t_mode_code MODE_DELETE    = MODE_W'(4);

    localparam t_stat_code STAT_OK     = STAT_W'(0);
    localparam t_stat_code STAT_FULL   = STAT_W'(1);
    localparam t_stat_code STAT_EMPTY  = STAT_W'(2);
    localparam t_stat_code STAT_NOSLOT = STAT_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SWAP_RB,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DEL_MOVE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_HEAD,
        RD_SA,
        RD_SB,
        RD_NEXT_J,
        RD_NEXT_NJ
    } t_rd_src;

    typedef enum logic [1:0] {
        WR_PUSH,
        WR_SA_RDATA,
        WR_SB_HOLD,
        WR_J_RDATA
    } t_wr_src;

    typedef struct packed {
        logic    load_op;
        logic    decode;
        logic    do_push;
        logic    do_pop;
        logic    rd_en;
        t_rd_src rd_src;
        logic    hold_rd;
        logic    wr_en;
        t_wr_src wr_src;
        logic    del_step;
        logic    del_finish;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode_code mode;
        logic       err;
        logic       j_at_tail;
        logic       nj_at_tail;
        logic       out_free;
    } t_dp_stat;

    function automatic t_ptr ring_next(input t_ptr p);
        return (p == t_ptr'(DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ring_prev(input t_ptr p);
        return (p == '0) ? t_ptr'(DEPTH - 1) : p - t_ptr'(1);
    endfunction

    function automatic t_cnt held_count(input logic empty, input t_ptr head, input t_ptr tail);
        t_cnt h;
        t_cnt t;
        h = t_cnt'(head);
        t = t_cnt'(tail);
        if (empty) begin
            return '0;
        end
        if (t >= h) begin
            return t - h + t_cnt'(1);
        end
        return t + t_cnt'(DEPTH) - h + t_cnt'(1);
    endfunction

    function automatic logic is_live(input t_slot s, input logic empty,
                                     input t_ptr head, input t_ptr tail);
        t_cnt se;
        t_cnt h;
        t_cnt off;
        se = t_cnt'(s);
        h  = t_cnt'(head);
        if (empty || se >= t_cnt'(DEPTH)) begin
            return 1'b0;
        end
        off = (se >= h) ? se - h : se + t_cnt'(DEPTH) - h;
        return off < held_count(empty, head, tail);
    endfunction

endpackage

`default_nettype wire

FILE: src/cdq_if.sv
`default_nettype none

interface cdq_in_if import cdq_pkg::*; ();
    logic       valid;
    logic       ready;
    t_mode_code mode;
    t_data      data_in;
    t_slot      slot_a;
    t_slot      slot_b;

    modport source (output valid, mode, data_in, slot_a, slot_b, input ready);
    modport sink   (input valid, mode, data_in, slot_a, slot_b, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
    logic       valid;
    logic       ready;
    t_data      data_out;
    t_stat_code status;
    logic       now_empty;
    logic       now_full;
    t_cnt       entry_count;

    modport source (output valid, data_out, status, now_empty, now_full, entry_count,
                    input ready);
    modport sink   (input valid, data_out, status, now_empty, now_full, entry_count,
                    output ready);
endinterface

`default_nettype wire

FILE: src/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl import cdq_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_op = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_DONE;
                if (!i_stat.err) begin
                    unique case (i_stat.mode)
                        MODE_PUSH_TAIL, MODE_PUSH_HEAD: begin
                            o_cmd.do_push = 1'b1;
                        end
                        MODE_POP_HEAD: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = RD_HEAD;
                            o_cmd.do_pop = 1'b1;
                        end
                        MODE_SWAP: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_src = RD_SA;
                            n_state      = S_SWAP_RB;
                        end
                        MODE_DELETE: begin
                            // slot is already the tail: nothing to shift
                            if (i_stat.j_at_tail) begin
                                o_cmd.del_finish = 1'b1;
                            end else begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_src = RD_NEXT_J;
                                n_state      = S_DEL_MOVE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SWAP_RB: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_src  = RD_SB;
                o_cmd.hold_rd = 1'b1;
                n_state       = S_SWAP_WA;
            end
            S_SWAP_WA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_SA_RDATA;
                n_state      = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_SB_HOLD;
                n_state      = S_DONE;
            end
            S_DEL_MOVE: begin
                // write the word fetched last cycle, fetch the one after it
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_src   = WR_J_RDATA;
                o_cmd.del_step = 1'b1;
                if (i_stat.nj_at_tail) begin
                    o_cmd.del_finish = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_NEXT_NJ;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/cdq_dp.sv
`default_nettype none

module cdq_dp import cdq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire t_mode_code i_mode,
    input  wire t_data      i_data_in,
    input  wire t_slot      i_slot_a,
    input  wire t_slot      i_slot_b,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output t_data           o_data_out,
    output t_stat_code      o_status,
    output logic            o_now_empty,
    output logic            o_now_full,
    output t_cnt            o_entry_count
);

    t_data      r_mem [DEPTH];

    t_mode_code r_mode;
    t_data      r_data;
    t_slot      r_sa;
    t_slot      r_sb;
    t_ptr       r_j;
    t_ptr       r_head;
    t_ptr       r_tail;
    logic       r_empty;
    t_data      r_rdata;
    t_data      r_hold;
    t_stat_code r_status;
    logic       r_pop_ok;

    logic       r_out_valid;
    t_data      r_out_data;
    t_stat_code r_out_status;
    logic       r_out_empty;
    logic       r_out_full;
    t_cnt       r_out_cnt;

    t_cnt       cnt;
    t_stat_code st;
    t_ptr       push_addr;
    t_ptr       rd_addr;
    t_ptr       wr_addr;
    t_data      wr_data;

    assign cnt = held_count(r_empty, r_head, r_tail);

    always_comb begin
        case (r_mode) inside
            MODE_PUSH_TAIL, MODE_PUSH_HEAD: begin
                st = (cnt >= t_cnt'(DEPTH)) ? STAT_FULL : STAT_OK;
            end
            MODE_POP_HEAD: begin
                st = r_empty ? STAT_EMPTY : STAT_OK;
            end
            MODE_SWAP: begin
                if (r_empty) begin
                    st = STAT_EMPTY;
                end else if (!is_live(r_sa, r_empty, r_head, r_tail) ||
                             !is_live(r_sb, r_empty, r_head, r_tail)) begin
                    st = STAT_NOSLOT;
                end else begin
                    st = STAT_OK;
                end
            end
            MODE_DELETE: begin
                if (r_empty) begin
                    st = STAT_EMPTY;
                end else if (!is_live(r_sa, r_empty, r_head, r_tail)) begin
                    st = STAT_NOSLOT;
                end else begin
                    st = STAT_OK;
                end
            end
            default: begin
                st = STAT_OK;
            end
        endcase
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.err        = (st != STAT_OK);
    assign o_stat.j_at_tail  = (r_j == r_tail);
    assign o_stat.nj_at_tail = (ring_next(r_j) == r_tail);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_empty) begin
            push_addr = '0;
        end else if (r_mode == MODE_PUSH_TAIL) begin
            push_addr = ring_next(r_tail);
        end else begin
            push_addr = ring_prev(r_head);
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            RD_HEAD:    rd_addr = r_head;
            RD_SA:      rd_addr = t_ptr'(r_sa);
            RD_SB:      rd_addr = t_ptr'(r_sb);
            RD_NEXT_J:  rd_addr = ring_next(r_j);
            RD_NEXT_NJ: rd_addr = ring_next(ring_next(r_j));
            default:    rd_addr = r_head;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_src)
            WR_PUSH: begin
                wr_addr = push_addr;
                wr_data = r_data;
            end
            WR_SA_RDATA: begin
                wr_addr = t_ptr'(r_sa);
                wr_data = r_rdata;
            end
            WR_SB_HOLD: begin
                wr_addr = t_ptr'(r_sb);
                wr_data = r_hold;
            end
            default: begin
                wr_addr = r_j;
                wr_data = r_rdata;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en || i_cmd.do_push) begin
            r_mem[i_cmd.do_push ? push_addr : wr_addr] <= i_cmd.do_push ? r_data : wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_mode <= i_mode;
            r_data <= i_data_in;
            r_sa   <= i_slot_a;
            r_sb   <= i_slot_b;
        end
        if (i_cmd.load_op) begin
            r_j <= t_ptr'(i_slot_a);
        end else if (i_cmd.del_step) begin
            r_j <= ring_next(r_j);
        end
        if (i_cmd.hold_rd) begin
            r_hold <= r_rdata;
        end
        if (i_cmd.decode) begin
            r_status <= st;
            r_pop_ok <= (r_mode == MODE_POP_HEAD) && (st == STAT_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.do_push) begin
            if (r_empty) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b0;
            end else if (r_mode == MODE_PUSH_TAIL) begin
                r_tail <= ring_next(r_tail);
            end else begin
                r_head <= ring_prev(r_head);
            end
        end else if (i_cmd.do_pop || i_cmd.del_finish) begin
            // last entry gone: drop back to the reset position
            if (r_head == r_tail) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_empty <= 1'b1;
            end else if (i_cmd.do_pop) begin
                r_head <= ring_next(r_head);
            end else begin
                r_tail <= ring_prev(r_tail);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= r_pop_ok ? r_rdata : '0;
            r_out_status <= r_status;
            r_out_empty  <= r_empty;
            r_out_full   <= (cnt == t_cnt'(DEPTH));
            r_out_cnt    <= cnt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_out_data;
    assign o_status      = r_out_status;
    assign o_now_empty   = r_out_empty;
    assign o_now_full    = r_out_full;
    assign o_entry_count = r_out_cnt;

endmodule

`default_nettype wire

FILE: src/circular_deque_with_slot_delete_core.sv
// Circular deque of 16 words with push at either end, pop at the head,
// slot swap and slot delete.
// Channels: i_in carries one operation per beat (mode, data_in, slot_a,
// slot_b); o_out returns exactly one result beat per operation (data_out,
// status, now_empty, now_full, entry_count). A beat moves when valid and
// ready are both high.
// Timing: one operation at a time. An accepted beat is decoded in the next
// cycle; push, pop, rejected and unknown operations then go straight to the
// output register, loaded once it is free. Swap does two reads and two
// writes through the one read port and one write port of the slot memory.
// Delete moves each entry after the deleted slot, up to and including the
// tail, down one slot, one slot move per cycle, then the tail steps back.
// Reset (synchronous, active low) empties the deque and clears the output
// valid flag; slot contents are not cleared.
// Stall: while o_out is stalled the result is held, the next beat is still
// accepted and worked on, and its result waits until the register is free.
`default_nettype none

module circular_deque_with_slot_delete_core import cdq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdq_in_if.sink     i_in,
    cdq_out_if.source  o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    cdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    cdq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_in.mode),
        .i_data_in     (i_in.data_in),
        .i_slot_a      (i_in.slot_a),
        .i_slot_b      (i_in.slot_b),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_data_out    (o_out.data_out),
        .o_status      (o_out.status),
        .o_now_empty   (o_out.now_empty),
        .o_now_full    (o_out.now_full),
        .o_entry_count (o_out.entry_count)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

FILE: src/cdq_chk.sv
`default_nettype none

module cdq_chk import cdq_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire t_data      i_data_out,
    input wire t_stat_code i_status,
    input wire logic       i_now_empty,
    input wire logic       i_now_full,
    input wire t_cnt       i_entry_count
);

    // one operation in flight: no beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while an operation is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out))
        else $error("stalled result changed");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_now_empty == (i_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_now_full == (i_entry_count == t_cnt'(DEPTH))))
        else $error("full flag disagrees with entry count");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_data_out != '0) |-> (i_status == STAT_OK))
        else $error("data returned with a rejected operation");

endmodule

bind circular_deque_with_slot_delete_core cdq_chk u_cdq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_data_out    (o_out.data_out),
    .i_status      (o_out.status),
    .i_now_empty   (o_out.now_empty),
    .i_now_full    (o_out.now_full),
    .i_entry_count (o_out.entry_count)
);

`default_nettype wire
